// ===== rtl/gpg_pkg.sv =====
`timescale 1ns / 1ps
package gpg_pkg;

    localparam int QB        = 28;
    localparam int QW        = QB + 1;
    localparam int NORM_W    = 64;
    localparam int X_W       = QB + 1;
    localparam int R_W       = 32;
    localparam int E_W       = 8;
    localparam int ELN_W     = 40;
    localparam int TL_W      = 36;
    localparam int TL_SPLIT  = 18;
    localparam int PROD_W    = 64;
    localparam int SQ_STEPS  = 32;
    localparam int VAR_W     = 32;
    localparam int MU_W      = 32;
    localparam int SIG_W     = 31;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 8'd1;

    localparam logic signed [R_W-1:0] K_A   = 32'sd120038846;
    localparam logic signed [R_W-1:0] K_B   = 32'sd15185622;
    localparam logic signed [R_W-1:0] K_C   = 32'sd394588524;
    localparam logic signed [R_W-1:0] K_D   = 32'sd757310806;
    localparam logic signed [R_W-1:0] K_E   = 32'sd467559240;
    localparam logic signed [R_W-1:0] K_LN2 = 32'sd186065280;

endpackage

// ===== rtl/gpg_div.sv =====
`timescale 1ns / 1ps
module gpg_div
    import gpg_pkg::*;
#(
    parameter int NW = 32,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] out_side
);

    // one restoring step per stage; num <= den
    logic [QW-1:0] vld_reg;
    logic [NW:0]   rem_reg  [QW-1];
    logic [NW-1:0] den_reg  [QW-1];
    logic [QW-1:0] q_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic          vi;
            logic [NW:0]   ri;
            logic [NW:0]   rs;
            logic [NW:0]   rn;
            logic [NW-1:0] di;
            logic [QW-1:0] qi;
            logic [SW-1:0] si;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign vi = in_valid;
                assign ri = {1'b0, num};
                assign di = den;
                assign qi = '0;
                assign si = in_side;
                assign rs = ri;
            end
            else
            begin : g_next
                assign vi = vld_reg[k-1];
                assign ri = rem_reg[k-1];
                assign di = den_reg[k-1];
                assign qi = q_reg[k-1];
                assign si = side_reg[k-1];
                assign rs = {ri[NW-1:0], 1'b0};
            end

            assign ge = (rs >= {1'b0, di});
            assign rn = ge ? (rs - {1'b0, di}) : rs;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[k]    <= {qi[QW-2:0], ge};
                    side_reg[k] <= si;
                end
            end

            if (k < QW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= rn;
                        den_reg[k] <= di;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== rtl/gpg_sqrt.sv =====
`timescale 1ns / 1ps
module gpg_sqrt
    import gpg_pkg::*;
#(
    parameter int SW = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [PROD_W-1:0] radicand,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [VAR_W-1:0]  root,
    output logic [SW-1:0]     out_side
);

    // one result bit per stage
    logic [SQ_STEPS-1:0] vld_reg;
    logic [PROD_W-1:0]   v_reg    [SQ_STEPS-1];
    logic [PROD_W-1:0]   res_reg  [SQ_STEPS];
    logic [SW-1:0]       side_reg [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_step
            localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (62 - 2 * k);
            logic              vi;
            logic [PROD_W-1:0] vin;
            logic [PROD_W-1:0] rin;
            logic [SW-1:0]     si;
            logic [PROD_W-1:0] trial;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign vi  = in_valid;
                assign vin = radicand;
                assign rin = '0;
                assign si  = in_side;
            end
            else
            begin : g_next
                assign vi  = vld_reg[k-1];
                assign vin = v_reg[k-1];
                assign rin = res_reg[k-1];
                assign si  = side_reg[k-1];
            end

            assign trial = rin + BIT;
            assign ge    = (vin >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    res_reg[k]  <= ge ? ((rin >> 1) + BIT) : (rin >> 1);
                    side_reg[k] <= si;
                end
            end

            if (k < SQ_STEPS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        v_reg[k] <= ge ? (vin - trial) : vin;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign root      = res_reg[SQ_STEPS-1][VAR_W-1:0];
    assign out_side  = side_reg[SQ_STEPS-1];

endmodule

// ===== rtl/gaussian_polar_generator.sv =====
`timescale 1ns / 1ps
// Gaussian sample generator, polar method, fully pipelined. Each input transaction carries a
// pair of uniform samples; pairs with w = u1^2 + u2^2 equal to 0 or at least 1 are dropped.
// A kept pair yields two output transactions, mu + sigma*variate1 and then mu + sigma*variate2
// with tlast set. The pipeline takes a new pair every cycle that it is not stalled; the output
// port delivers one sample per cycle while m_axis_tready is high, and a dropped pair uses only
// its input slot. From input to first sample the path runs through squaring, normalization
// and the log polynomial, the radix-2 divider, the split multiply, the square root, and
// scaling and saturation. One global enable stalls every stage while the output stage holds
// a pair whose second sample has not been taken.
// Configuration writes are always ready and take effect on the next cycle.
module gaussian_polar_generator
    import gpg_pkg::*;
#(
    parameter int UNIFORM_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // uniform_a, uniform_b, zero pad
    input  logic [((2*UNIFORM_FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sample
    output logic [31:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int F   = UNIFORM_FRAC_BITS;
    localparam int UFW = F + 1;
    localparam int SQW = 2 * F + 1;
    localparam int WSW = 2 * F + 2;
    localparam int NW  = 2 * F;
    localparam int SDW = TL_W + 1;

    function automatic logic signed [R_W-1:0] mulq(input logic signed [R_W-1:0] a,
                                                   input logic signed [R_W-1:0] b);
        logic signed [2*R_W-1:0] p;
        p = a * b;
        return p[QB+R_W-1:QB];
    endfunction

    function automatic logic [MU_W-1:0] finish(input logic signed [MU_W-1:0] mu,
                                               input logic [62:0] sm,
                                               input logic neg);
        logic [63:0]        rnd;
        logic signed [37:0] m;
        logic signed [37:0] val;
        rnd = {1'b0, sm} + (64'd1 << (QB - 1));
        m   = $signed({2'b00, rnd[63:QB]});
        val = neg ? (38'(mu) - m) : (38'(mu) + m);
        if (val > 38'sd2147483647)
            return 32'h7fffffff;
        else if (val < -38'sd2147483648)
            return 32'h80000000;
        else
            return val[MU_W-1:0];
    endfunction

    logic                    en;
    logic signed [MU_W-1:0]  mu_reg;
    logic [SIG_W-1:0]        sigma_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= '0;
            sigma_reg <= SIG_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MEAN:  mu_reg    <= $signed(cfg_data);
                REG_SCALE: sigma_reg <= cfg_data[SIG_W-1:0];
                default:   ;
            endcase
        end
    end

    // stage 1: magnitudes
    logic [UFW-1:0] raw [2];
    logic [UFW-1:0] mag [2];
    logic           v1_reg;
    logic [UFW-1:0] mag1_reg [2];
    logic [1:0]     neg1_reg;

    assign raw[0] = s_axis_tdata[UFW-1:0];
    assign raw[1] = s_axis_tdata[2*UFW-1:UFW];
    assign mag[0] = raw[0][UFW-1] ? (~raw[0] + UFW'(1)) : raw[0];
    assign mag[1] = raw[1][UFW-1] ? (~raw[1] + UFW'(1)) : raw[1];

    // stage 2: squares
    logic [2*UFW-1:0] sqf [2];
    logic             v2_reg;
    logic [SQW-1:0]   sq2_reg [2];
    logic [1:0]       neg2_reg;

    assign sqf[0] = mag1_reg[0] * mag1_reg[0];
    assign sqf[1] = mag1_reg[1] * mag1_reg[1];

    // stage 3: w and rejection
    logic [WSW-1:0] wsum;
    logic           keep;
    logic           v3_reg;
    logic [NW-1:0]  w3_reg;
    logic [NW-1:0]  sq3_reg [2];
    logic [1:0]     neg3_reg;

    assign wsum = {1'b0, sq2_reg[0]} + {1'b0, sq2_reg[1]};
    assign keep = (wsum != '0) && (wsum < (WSW'(1) << NW));

    // normalization stages
    logic [NORM_W-1:0] n0, n1, n2, n3;
    logic [2:0]        lzh;
    logic              vn1_reg;
    logic [NORM_W-1:0] nrm1_reg;
    logic [2:0]        lzh1_reg;
    logic [NW-1:0]     wn1_reg;
    logic [NW-1:0]     sqn1_reg [2];
    logic [1:0]        negn1_reg;

    assign n0     = NORM_W'(w3_reg);
    assign lzh[2] = (n0[63:32] == '0);
    assign n1     = lzh[2] ? (n0 << 32) : n0;
    assign lzh[1] = (n1[63:48] == '0);
    assign n2     = lzh[1] ? (n1 << 16) : n1;
    assign lzh[0] = (n2[63:56] == '0);
    assign n3     = lzh[0] ? (n2 << 8) : n2;

    logic [NORM_W-1:0]      n4, n5, n6;
    logic [2:0]             lzl;
    logic signed [E_W-1:0]  e_n;
    logic                   vn2_reg;
    logic [X_W-1:0]         x2_reg;
    logic signed [E_W-1:0]  e2_reg;
    logic [NW-1:0]          wn2_reg;
    logic [NW-1:0]          sqn2_reg [2];
    logic [1:0]             negn2_reg;

    assign lzl[2] = (nrm1_reg[63:60] == '0);
    assign n4     = lzl[2] ? (nrm1_reg << 4) : nrm1_reg;
    assign lzl[1] = (n4[63:62] == '0);
    assign n5     = lzl[1] ? (n4 << 2) : n4;
    assign lzl[0] = ~n5[63];
    assign n6     = lzl[0] ? (n5 << 1) : n5;
    assign e_n    = $signed(E_W'(63 - 2 * F)) - $signed({2'b00, lzh1_reg, lzl});

    // log polynomial stages
    logic signed [R_W-1:0]   xs;
    logic signed [R_W-1:0]   r_reg  [4];
    logic [3:0]              vp_reg;
    logic [X_W-1:0]          xp_reg [3];
    logic signed [ELN_W-1:0] eln_reg [4];
    logic [NW-1:0]           wp_reg [4];
    logic [NW-1:0]           sqp_reg [4][2];
    logic [1:0]              negp_reg [4];

    assign xs = $signed({3'b000, x2_reg});

    // 2*L
    logic signed [ELN_W-1:0] lnv;
    logic signed [ELN_W-1:0] lnv_neg;
    logic                    vl_reg;
    logic [TL_W-1:0]         tl_reg;
    logic [NW-1:0]           wl_reg;
    logic [NW-1:0]           sql_reg [2];
    logic [1:0]              negl_reg;

    assign lnv     = ELN_W'(r_reg[3]) + eln_reg[3];
    assign lnv_neg = -lnv;

    // per-lane back end
    logic                  dv    [2];
    logic [QW-1:0]         quot  [2];
    logic [SDW-1:0]        dside [2];
    logic                  vm1_reg;
    logic [46:0]           pl_reg [2];
    logic [46:0]           ph_reg [2];
    logic [1:0]            negm1_reg;
    logic                  vm2_reg;
    logic [PROD_W-1:0]     prod_reg [2];
    logic [1:0]            negm2_reg;
    logic                  sv    [2];
    logic [VAR_W-1:0]      root  [2];
    logic                  sside [2];
    logic                  vo1_reg;
    logic [62:0]           sm_reg [2];
    logic [1:0]            nego1_reg;
    logic                  fv_reg;
    logic                  phase_reg;
    logic [MU_W-1:0]       samp_reg [2];

    assign en            = !fv_reg || (m_axis_tready && phase_reg);
    assign s_axis_tready = en;

    genvar ln;
    generate
        for (ln = 0; ln < 2; ln++)
        begin : g_lane
            gpg_div #(
                .NW (NW),
                .SW (SDW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (vl_reg),
                .num       (sql_reg[ln]),
                .den       (wl_reg),
                .in_side   ({tl_reg, negl_reg[ln]}),
                .out_valid (dv[ln]),
                .quot      (quot[ln]),
                .out_side  (dside[ln])
            );

            gpg_sqrt #(
                .SW (1)
            ) u_sqrt (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (vm2_reg),
                .radicand  (prod_reg[ln]),
                .in_side   (negm2_reg[ln]),
                .out_valid (sv[ln]),
                .root      (root[ln]),
                .out_side  (sside[ln])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pl_reg[ln]    <= dside[ln][TL_SPLIT:1] * quot[ln];
                    ph_reg[ln]    <= dside[ln][TL_W:TL_SPLIT+1] * quot[ln];
                    negm1_reg[ln] <= dside[ln][0];
                    prod_reg[ln]  <= (PROD_W'(ph_reg[ln]) << TL_SPLIT) + PROD_W'(pl_reg[ln]);
                    negm2_reg[ln] <= negm1_reg[ln];
                    sm_reg[ln]    <= sigma_reg * root[ln];
                    nego1_reg[ln] <= sside[ln];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vn1_reg <= 1'b0;
            vn2_reg <= 1'b0;
            vp_reg  <= '0;
            vl_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vo1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= s_axis_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg && keep;
            vn1_reg <= v3_reg;
            vn2_reg <= vn1_reg;
            vp_reg  <= {vp_reg[2:0], vn2_reg};
            vl_reg  <= vp_reg[3];
            vm1_reg <= dv[0] && dv[1];
            vm2_reg <= vm1_reg;
            vo1_reg <= sv[0] && sv[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg[0] <= mag[0];
            mag1_reg[1] <= mag[1];
            neg1_reg    <= {raw[1][UFW-1], raw[0][UFW-1]};

            sq2_reg[0] <= sqf[0][SQW-1:0];
            sq2_reg[1] <= sqf[1][SQW-1:0];
            neg2_reg   <= neg1_reg;

            w3_reg     <= wsum[NW-1:0];
            sq3_reg[0] <= sq2_reg[0][NW-1:0];
            sq3_reg[1] <= sq2_reg[1][NW-1:0];
            neg3_reg   <= neg2_reg;

            nrm1_reg    <= n3;
            lzh1_reg    <= lzh;
            wn1_reg     <= w3_reg;
            sqn1_reg[0] <= sq3_reg[0];
            sqn1_reg[1] <= sq3_reg[1];
            negn1_reg   <= neg3_reg;

            x2_reg      <= n6[NORM_W-1:NORM_W-X_W];
            e2_reg      <= e_n;
            wn2_reg     <= wn1_reg;
            sqn2_reg[0] <= sqn1_reg[0];
            sqn2_reg[1] <= sqn1_reg[1];
            negn2_reg   <= negn1_reg;

            r_reg[0]      <= K_A - mulq(K_B, xs);
            xp_reg[0]     <= x2_reg;
            eln_reg[0]    <= ELN_W'(e2_reg) * ELN_W'(K_LN2);
            wp_reg[0]     <= wn2_reg;
            sqp_reg[0][0] <= sqn2_reg[0];
            sqp_reg[0][1] <= sqn2_reg[1];
            negp_reg[0]   <= negn2_reg;

            r_reg[1] <= mulq(r_reg[0], $signed({3'b000, xp_reg[0]})) - K_C;
            r_reg[2] <= mulq(r_reg[1], $signed({3'b000, xp_reg[1]})) + K_D;
            r_reg[3] <= mulq(r_reg[2], $signed({3'b000, xp_reg[2]})) - K_E;
            xp_reg[1] <= xp_reg[0];
            xp_reg[2] <= xp_reg[1];
            for (int i = 1; i < 4; i++)
            begin
                eln_reg[i]    <= eln_reg[i-1];
                wp_reg[i]     <= wp_reg[i-1];
                sqp_reg[i][0] <= sqp_reg[i-1][0];
                sqp_reg[i][1] <= sqp_reg[i-1][1];
                negp_reg[i]   <= negp_reg[i-1];
            end

            tl_reg     <= lnv[ELN_W-1] ? {lnv_neg[TL_W-2:0], 1'b0} : '0;
            wl_reg     <= wp_reg[3];
            sql_reg[0] <= sqp_reg[3][0];
            sql_reg[1] <= sqp_reg[3][1];
            negl_reg   <= negp_reg[3];

            samp_reg[0] <= finish(mu_reg, sm_reg[0], nego1_reg[0]);
            samp_reg[1] <= finish(mu_reg, sm_reg[1], nego1_reg[1]);
        end
    end

    // output pair: first sample, then second with tlast
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg    <= vo1_reg;
            phase_reg <= 1'b0;
        end
        else if (m_axis_tready)
        begin
            phase_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = fv_reg;
    assign m_axis_tdata  = phase_reg ? samp_reg[1] : samp_reg[0];
    assign m_axis_tlast  = phase_reg;

`ifndef SYNTHESIS
    a_phase_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> fv_reg)
        else $error("second-sample phase without a held pair");

    a_div_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        dv[0] == dv[1])
        else $error("divider lanes out of step");

    a_sqrt_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        sv[0] == sv[1])
        else $error("sqrt lanes out of step");

    a_pair_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (fv_reg && phase_reg && m_axis_tready) |=> (fv_reg == $past(vo1_reg)))
        else $error("output stage did not reload after last transaction");
`endif

endmodule

// ===== verif/gpg_checker.sv =====
`timescale 1ns / 1ps
module gpg_checker
    import gpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          samples_seen
);

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_t;

    sample_t     sample_q[$];
    logic signed [31:0] mu;
    logic [30:0] sigma;

    assign pending = sample_q.size();

    function automatic longint floor_q28(longint p);
        if (p >= 0)
            return p >>> QB;
        return -((-p + (64'd1 << QB) - 1) >>> QB);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] scaled_sample(longint unsigned sq, logic neg,
                                                  longint unsigned w, longint unsigned twice_l);
        longint unsigned ratio;
        longint unsigned v;
        longint unsigned m;
        longint val;
        ratio = (sq << QB) / w;
        v = int_sqrt(twice_l * ratio);
        m = (longint'(sigma) * v + (64'd1 << (QB - 1))) >> QB;
        val = neg ? longint'(mu) - longint'(m) : longint'(mu) + longint'(m);
        if (val > 64'sd2147483647)
            val = 64'sd2147483647;
        if (val < -64'sd2147483648)
            val = -64'sd2147483648;
        return val[31:0];
    endfunction

    task automatic predict_pair(logic [16:0] ua, logic [16:0] ub);
        longint unsigned ma, mb, sa, sb, w, x, twice_l;
        longint r, lnv;
        int p, e;
        sample_t s;
        ma = ua[16] ? (64'd1 << 17) - ua : ua;
        mb = ub[16] ? (64'd1 << 17) - ub : ub;
        sa = ma * ma;
        sb = mb * mb;
        w = sa + sb;
        if (w == 0 || w >= (64'd1 << 32))
            return;
        p = 63;
        while (w[p] == 1'b0)
            p--;
        x = (p >= QB) ? (w >> (p - QB)) : (w << (QB - p));
        e = p - 32;
        r = longint'(K_A) - floor_q28(longint'(K_B) * longint'(x));
        r = -longint'(K_C) + floor_q28(r * longint'(x));
        r = longint'(K_D) + floor_q28(r * longint'(x));
        r = -longint'(K_E) + floor_q28(r * longint'(x));
        lnv = r + longint'(e) * longint'(K_LN2);
        twice_l = (lnv < 0) ? longint'(-lnv) * 2 : 0;
        s.sample = scaled_sample(sa, ua[16], w, twice_l);
        s.last = 1'b0;
        sample_q.push_back(s);
        s.sample = scaled_sample(sb, ub[16], w, twice_l);
        s.last = 1'b1;
        sample_q.push_back(s);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        samples_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu <= '0;
            sigma <= 31'd65536;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MEAN)
                    mu <= cfg_data;
                else if (cfg_index == REG_SCALE)
                    sigma <= cfg_data[30:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pair(s_axis_tdata[16:0], s_axis_tdata[33:17]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sample_t want;
                samples_seen++;
                if (sample_q.size() == 0)
                    report_mismatch("unexpected transaction", m_axis_tdata, '0);
                else
                begin
                    want = sample_q.pop_front();
                    if (m_axis_tdata !== want.sample)
                        report_mismatch("sample", m_axis_tdata, want.sample);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import gpg_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          samples_seen;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          pairs_sent = 0;

    always #4 clk = ~clk;

    gaussian_polar_generator uut (.*);

    gpg_checker chk (.*);

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // tvalid stays high after a transaction; the next idle cycle or drain() drops it
    task automatic send_pair(logic [16:0] ua, logic [16:0] ub);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, ub, ua};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pairs_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [16:0] rand_uniform(int kept);
        logic [16:0] u;
        if (kept != 0)
            u = 17'($signed($urandom_range(92680)) - 46340);
        else
            u = 17'($urandom);
        return u;
    endfunction

    task automatic random_pairs(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
                send_pair(rand_uniform(1), rand_uniform(1));
            else
                send_pair(rand_uniform(0), rand_uniform(0));
        end
    endtask

    initial
    begin
        logic [16:0] edge_vals[12];
        edge_vals = '{17'h10000, 17'h0ffff, 17'h00000, 17'h00001, 17'h1ffff, 17'h0b505,
                      17'h14afb, 17'h00100, 17'h08000, 17'h18000, 17'h0b504, 17'h00002};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 12; i++)
            send_pair(edge_vals[i], edge_vals[(i * 5 + 3) % 12]);
        send_pair(17'h00000, 17'h00000);
        send_pair(17'h00001, 17'h00000);
        send_pair(17'h00000, 17'h1ffff);
        send_pair(17'h0ffff, 17'h00001);
        send_pair(17'h0b504, 17'h0b504);
        send_pair(17'h0b505, 17'h0b505);
        drain();

        send_idle_pct = 26;
        recv_idle_pct = 75;
        write_reg(REG_MEAN, 32'h8000_0000);
        write_reg(REG_SCALE, 32'hffff_ffff);
        write_reg(8'd7, 32'h1234_5678);
        random_pairs(60);
        drain();
        write_reg(REG_MEAN, 32'h7fff_ffff);
        write_reg(REG_SCALE, 32'h0000_0000);
        random_pairs(40);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 26;
        write_reg(REG_MEAN, $urandom);
        write_reg(REG_SCALE, $urandom_range(32'h0010_0000));
        random_pairs(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MEAN, 32'h0000_0000);
        write_reg(REG_SCALE, 32'h0001_0000);
        hold_req <= 1'b1;
        random_pairs(120);
        drain();
        write_reg(REG_MEAN, $urandom);
        write_reg(REG_SCALE, $urandom);
        random_pairs(120);
        drain();

        $display("covered %0d input pairs, %0d samples, range and scale extremes",
                 pairs_sent, samples_seen);
        $display("stall mixes: slow receiver, slow sender, back-to-back, long output hold");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
